// ===== rtl/generation_stamped_direct_table_core_defines.svh =====
// Assertion macros for the generation stamped direct table core.
// Used by the port checker; depends on nothing else.
`ifndef GENERATION_STAMPED_DIRECT_TABLE_CORE_DEFINES_SVH
`define GENERATION_STAMPED_DIRECT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define GSDT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define GSDT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after reset is sampled high.
`define GSDT_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gsdt_pkg.sv =====
// Shared constants and types for the generation stamped direct table.
// No dependencies; interfaces, core and key fold use it by scoped names.
package gsdt_pkg;

   localparam int unsigned ACT_W   = 3;
   localparam int unsigned KEY_W   = 12;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned POS_W   = 13;
   localparam int unsigned STAMP_W = 30;

   // generation wraps back to one once it has reached this value
   localparam logic [STAMP_W-1:0] GEN_LIMIT = STAMP_W'(2 << 28);
   localparam logic [STAMP_W-1:0] GEN_FIRST = STAMP_W'(1);

   typedef enum logic [ACT_W-1:0] {
      ACT_FETCH   = 3'd0,
      ACT_SEARCH  = 3'd1,
      ACT_INSERT  = 3'd2,
      ACT_ERASE   = 3'd3,
      ACT_CLEAR   = 3'd4,
      ACT_ITERATE = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_INDEX,
      ST_EXEC,
      ST_ITER_KEY,
      ST_ITER_ENTRY,
      ST_ITER_CHECK
   } state_type;

endpackage

// ===== rtl/gsdt_req_if.sv =====
// Request channel of the generation stamped direct table.
// Depends on gsdt_pkg for field widths.
interface gsdt_req_if;
   logic                          valid;
   logic                          ready;
   logic [gsdt_pkg::ACT_W-1:0]    action;
   logic [gsdt_pkg::KEY_W-1:0]    key;
   logic [gsdt_pkg::DATA_W-1:0]   data_in;
   logic [gsdt_pkg::POS_W-1:0]    cursor;

   modport source (output valid, action, key, data_in, cursor, input ready);
   modport sink (input valid, action, key, data_in, cursor, output ready);
endinterface

// ===== rtl/gsdt_rsp_if.sv =====
// Response channel of the generation stamped direct table.
// Depends on gsdt_pkg for field widths.
interface gsdt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          found;
   logic [gsdt_pkg::DATA_W-1:0]   data_out;
   logic [gsdt_pkg::KEY_W-1:0]    key_out;
   logic [gsdt_pkg::POS_W-1:0]    position_out;

   modport source (output valid, found, data_out, key_out, position_out, input ready);
   modport sink (input valid, found, data_out, key_out, position_out, output ready);
endinterface

// ===== rtl/generation_stamped_direct_table_core.sv =====
// Generation stamped direct table: top level with stamp, value and key-list memories.
// Depends on gsdt_pkg, gsdt_req_if, gsdt_rsp_if and gsdt_key_fold.
//
// Use: one request beat on req_bus carries an action (fetch-or-create, search,
// insert, erase, clear, iterate), a key, insert data and an iterate cursor.
// Every accepted beat yields exactly one response beat on rsp_bus, in order.
// csr_we/csr_wdata load the null value used by fetch-or-create; write it only
// while the block is idle.
// Sequence: the block holds one request at a time. A table action goes from
// idle to an index state, which reads the stamp and value at the folded key,
// then to an execute state, which registers the response. Iterate walks the
// key list from the cursor after the index state; each position is a key-list
// read followed by a stamp/value read, until a live entry or the list's end.
// Reset (synchronous, active high) starts a wipe of all TABLE_DEPTH stamp
// memory entries with req_bus.ready low; a clear that wraps the generation
// starts the same wipe after its response is registered. csr writes are
// taken throughout.
// Stall: the response sits in an output register; a new request is accepted
// while it waits, but the next response is held back until rsp_bus.ready.
module generation_stamped_direct_table_core #(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   gsdt_req_if.sink                      req_bus,
   gsdt_rsp_if.source                    rsp_bus,
   input  logic                          csr_we,
   input  logic [gsdt_pkg::DATA_W-1:0]   csr_wdata
);

   localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned PCMP_W = (CNT_W > gsdt_pkg::POS_W) ? CNT_W : gsdt_pkg::POS_W;
   localparam int unsigned KEY_W  = gsdt_pkg::KEY_W;
   localparam int unsigned DATA_W = gsdt_pkg::DATA_W;
   localparam int unsigned POS_W  = gsdt_pkg::POS_W;
   localparam int unsigned STAMP_W = gsdt_pkg::STAMP_W;

   // ---------------------------------------------------------------- state
   gsdt_pkg::state_type         state_ff, state_in;
   logic [STAMP_W-1:0]          gen_ff, gen_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [DATA_W-1:0]           null_ff, null_in;
   logic [IDX_W-1:0]            wipe_ff, wipe_in;

   // per-request working registers
   gsdt_pkg::action_type        act_ff;
   logic [DATA_W-1:0]           data_ff;
   logic [PCMP_W-1:0]           pos_ff, pos_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        hit_ff, hit_in;

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [DATA_W-1:0]           rsp_data_ff, rsp_data_in;
   logic [KEY_W-1:0]            rsp_key_ff, rsp_key_in;
   logic [POS_W-1:0]            rsp_pos_ff, rsp_pos_in;

   // memories and their ports
   logic [STAMP_W-1:0]          stamp_mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0]      value_mem [TABLE_DEPTH];
   logic [KEY_W-1:0]            list_mem  [TABLE_DEPTH];

   logic [STAMP_W-1:0]          stamp_rd_ff;
   logic [VALUE_WIDTH-1:0]      value_rd_ff;
   logic [KEY_W-1:0]            list_rd_ff;

   logic                        entry_ren;
   logic [IDX_W-1:0]            entry_raddr;
   logic                        stamp_we;
   logic [IDX_W-1:0]            stamp_waddr;
   logic [STAMP_W-1:0]          stamp_wdata;
   logic                        value_we;
   logic [VALUE_WIDTH-1:0]      value_wdata;
   logic                        list_we;
   logic                        list_ren;

   // ------------------------------------------------------------- datapath
   logic                        req_ready;
   logic                        accept;
   logic                        out_free;
   logic                        live;
   logic                        count_full;
   logic                        past_end;
   logic [IDX_W-1:0]            fold_idx;
   logic [IDX_W-1:0]            list_idx;
   logic [KEY_W-1:0]            idx_key;
   logic [VALUE_WIDTH-1:0]      null_val;
   logic [VALUE_WIDTH-1:0]      data_val;
   logic [DATA_W-1:0]           null_out;
   logic [DATA_W-1:0]           value_out;
   logic [POS_W-1:0]            count_pos;

   logic [IDX_W+KEY_W-1:0]      list_ext;
   logic [KEY_W+IDX_W-1:0]      idx_ext;
   logic [VALUE_WIDTH+DATA_W-1:0] null_ext;
   logic [VALUE_WIDTH+DATA_W-1:0] data_ext;
   logic [DATA_W+VALUE_WIDTH-1:0] null_back;
   logic [DATA_W+VALUE_WIDTH-1:0] value_back;
   logic [POS_W+CNT_W-1:0]      count_ext;

   assign accept   = req_bus.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign live     = (stamp_rd_ff == gen_ff);
   assign count_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign past_end = (pos_ff >= PCMP_W'(count_ff));

   // width adaptation: zero-extend then take the low bits
   assign list_ext   = {{IDX_W{1'b0}}, list_rd_ff};
   assign list_idx   = list_ext[IDX_W-1:0];
   assign idx_ext    = {{KEY_W{1'b0}}, idx_ff};
   assign idx_key    = idx_ext[KEY_W-1:0];
   assign null_ext   = {{VALUE_WIDTH{1'b0}}, null_ff};
   assign null_val   = null_ext[VALUE_WIDTH-1:0];
   assign data_ext   = {{VALUE_WIDTH{1'b0}}, data_ff};
   assign data_val   = data_ext[VALUE_WIDTH-1:0];
   assign null_back  = {{DATA_W{1'b0}}, null_val};
   assign null_out   = null_back[DATA_W-1:0];
   assign value_back = {{DATA_W{1'b0}}, value_rd_ff};
   assign value_out  = value_back[DATA_W-1:0];
   assign count_ext  = {{POS_W{1'b0}}, count_ff};
   assign count_pos  = count_ext[POS_W-1:0];

   gsdt_key_fold #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_key_fold (
      .clock (clock),
      .load  (accept),
      .key   (req_bus.key),
      .index (fold_idx)
   );

   // ----------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gsdt_pkg::ST_WIPE: begin
            if (wipe_ff == IDX_W'(TABLE_DEPTH - 1)) state_in = gsdt_pkg::ST_IDLE;
         end
         gsdt_pkg::ST_IDLE: begin
            if (accept) state_in = gsdt_pkg::ST_INDEX;
         end
         gsdt_pkg::ST_INDEX: begin
            if (act_ff == gsdt_pkg::ACT_ITERATE) state_in = gsdt_pkg::ST_ITER_KEY;
            else state_in = gsdt_pkg::ST_EXEC;
         end
         gsdt_pkg::ST_ITER_KEY: begin
            if (past_end) state_in = gsdt_pkg::ST_EXEC;
            else state_in = gsdt_pkg::ST_ITER_ENTRY;
         end
         gsdt_pkg::ST_ITER_ENTRY: begin
            state_in = gsdt_pkg::ST_ITER_CHECK;
         end
         gsdt_pkg::ST_ITER_CHECK: begin
            if (live) state_in = gsdt_pkg::ST_EXEC;
            else state_in = gsdt_pkg::ST_ITER_KEY;
         end
         gsdt_pkg::ST_EXEC: begin
            if (out_free) begin
               if (act_ff == gsdt_pkg::ACT_CLEAR && gen_ff >= gsdt_pkg::GEN_LIMIT)
                  state_in = gsdt_pkg::ST_WIPE;
               else
                  state_in = gsdt_pkg::ST_IDLE;
            end
         end
         default: state_in = gsdt_pkg::ST_IDLE;
      endcase
   end

   // -------------------------------------------------- outputs and datapath
   always_comb begin
      req_ready    = 1'b0;
      entry_ren    = 1'b0;
      entry_raddr  = fold_idx;
      stamp_we     = 1'b0;
      stamp_waddr  = idx_ff;
      stamp_wdata  = gen_ff;
      value_we     = 1'b0;
      value_wdata  = data_val;
      list_we      = 1'b0;
      list_ren     = 1'b0;

      gen_in       = gen_ff;
      count_in     = count_ff;
      wipe_in      = wipe_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      null_in      = csr_we ? csr_wdata : null_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_found_in = rsp_found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_pos_in   = rsp_pos_ff;

      unique case (state_ff)
         gsdt_pkg::ST_WIPE: begin
            stamp_we    = 1'b1;
            stamp_waddr = wipe_ff;
            stamp_wdata = '0;
            wipe_in     = wipe_ff + IDX_W'(1);
         end
         gsdt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) pos_in = PCMP_W'(req_bus.cursor);
         end
         gsdt_pkg::ST_INDEX: begin
            // folded key is ready now; fetch stamp and value
            entry_ren   = 1'b1;
            entry_raddr = fold_idx;
            idx_in      = fold_idx;
         end
         gsdt_pkg::ST_ITER_KEY: begin
            if (past_end) hit_in = 1'b0;
            else list_ren = 1'b1;
         end
         gsdt_pkg::ST_ITER_ENTRY: begin
            entry_ren   = 1'b1;
            entry_raddr = list_idx;
            idx_in      = list_idx;
         end
         gsdt_pkg::ST_ITER_CHECK: begin
            if (live) hit_in = 1'b1;
            else pos_in = pos_ff + PCMP_W'(1);
         end
         gsdt_pkg::ST_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_data_in  = '0;
               rsp_key_in   = '0;
               rsp_pos_in   = '0;
               unique case (act_ff)
                  gsdt_pkg::ACT_FETCH: begin
                     rsp_found_in = live;
                     rsp_data_in  = live ? value_out : null_out;
                     if (!live) begin
                        value_we    = 1'b1;
                        value_wdata = null_val;
                        stamp_we    = 1'b1;
                        list_we     = !count_full;
                        if (!count_full) count_in = count_ff + CNT_W'(1);
                     end
                  end
                  gsdt_pkg::ACT_SEARCH: begin
                     rsp_found_in = live;
                     rsp_data_in  = live ? value_out : '0;
                  end
                  gsdt_pkg::ACT_INSERT: begin
                     rsp_found_in = live;
                     value_we     = 1'b1;
                     value_wdata  = data_val;
                     if (!live) begin
                        stamp_we = 1'b1;
                        list_we  = !count_full;
                        if (!count_full) count_in = count_ff + CNT_W'(1);
                     end
                  end
                  gsdt_pkg::ACT_ERASE: begin
                     // stale even when already stale
                     rsp_found_in = live;
                     stamp_we     = 1'b1;
                     stamp_wdata  = gen_ff - STAMP_W'(1);
                  end
                  gsdt_pkg::ACT_CLEAR: begin
                     count_in = '0;
                     wipe_in  = '0;
                     if (gen_ff >= gsdt_pkg::GEN_LIMIT) gen_in = gsdt_pkg::GEN_FIRST;
                     else gen_in = gen_ff + STAMP_W'(1);
                  end
                  gsdt_pkg::ACT_ITERATE: begin
                     rsp_found_in = hit_ff;
                     if (hit_ff) begin
                        rsp_data_in = value_out;
                        rsp_key_in  = idx_key;
                        rsp_pos_in  = pos_ff[POS_W-1:0];
                     end else begin
                        rsp_pos_in  = count_pos;
                     end
                  end
                  default: begin
                     // undefined codes: all-zero response, no change
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsdt_pkg::ST_WIPE;
         gen_ff       <= gsdt_pkg::GEN_FIRST;
         count_ff     <= '0;
         null_ff      <= '0;
         wipe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         count_ff     <= count_in;
         null_ff      <= null_in;
         wipe_ff      <= wipe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= gsdt_pkg::action_type'(req_bus.action);
         data_ff <= req_bus.data_in;
      end
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      hit_ff       <= hit_in;
      rsp_found_ff <= rsp_found_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_pos_ff   <= rsp_pos_in;
   end

   // ------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (stamp_we) stamp_mem[stamp_waddr] <= stamp_wdata;
      if (entry_ren) stamp_rd_ff <= stamp_mem[entry_raddr];
   end

   always_ff @(posedge clock) begin
      if (value_we) value_mem[idx_ff] <= value_wdata;
      if (entry_ren) value_rd_ff <= value_mem[entry_raddr];
   end

   always_ff @(posedge clock) begin
      if (list_we) list_mem[count_ff[IDX_W-1:0]] <= idx_key;
      if (list_ren) list_rd_ff <= list_mem[pos_ff[IDX_W-1:0]];
   end

   // ---------------------------------------------------------------- ports
   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.data_out     = rsp_data_ff;
   assign rsp_bus.key_out      = rsp_key_ff;
   assign rsp_bus.position_out = rsp_pos_ff;

endmodule

// ===== rtl/gsdt_key_fold.sv =====
// Reduces a request key modulo the table depth by reciprocal multiply.
// Depends on gsdt_pkg. Quotient registered on load, remainder next cycle.
module gsdt_key_fold #(
   parameter int unsigned TABLE_DEPTH = 4096,
   parameter int unsigned IDX_W       = 12
) (
   input  logic                        clock,
   input  logic                        load,
   input  logic [gsdt_pkg::KEY_W-1:0]  key,
   output logic [IDX_W-1:0]            index
);

   // exact for every 12-bit key: the error of the reciprocal stays below 1/depth
   localparam int unsigned RECIP_SH = 24;
   localparam int unsigned RECIP_W  = RECIP_SH + 1;
   localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / TABLE_DEPTH + 1;
   localparam int unsigned PROD_W   = gsdt_pkg::KEY_W + RECIP_W;
   localparam int unsigned DEPTH_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned REM_W    = gsdt_pkg::KEY_W + DEPTH_W;

   logic [PROD_W-1:0]              prod;
   logic [gsdt_pkg::KEY_W-1:0]     quot_in;
   logic [gsdt_pkg::KEY_W-1:0]     quot_ff;
   logic [gsdt_pkg::KEY_W-1:0]     key_ff;
   logic [REM_W-1:0]               qd;
   logic [REM_W-1:0]               rem;

   assign prod    = PROD_W'(key) * PROD_W'(RECIP);
   assign quot_in = prod[RECIP_SH +: gsdt_pkg::KEY_W];

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff  <= key;
         quot_ff <= quot_in;
      end
   end

   assign qd    = REM_W'(quot_ff) * REM_W'(TABLE_DEPTH);
   assign rem   = REM_W'(key_ff) - qd;
   assign index = rem[IDX_W-1:0];

endmodule

// ===== rtl/gsdt_checker.sv =====
// Port-level checks for the generation stamped direct table core, with bind.
// Depends on the defines header and the two channel interfaces.
`include "generation_stamped_direct_table_core_defines.svh"

module gsdt_checker (
   input  logic         clock,
   input  logic         reset,
   gsdt_req_if.sink     req_bus,
   gsdt_rsp_if.source   rsp_bus
);

   `GSDT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_bus.valid && !rsp_bus.ready, rsp_bus.valid, "response beat dropped while stalled")
   `GSDT_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_bus.valid && !rsp_bus.ready, $stable(rsp_bus.found) && $stable(rsp_bus.data_out) && $stable(rsp_bus.key_out) && $stable(rsp_bus.position_out), "response payload moved while stalled")
   `GSDT_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_bus.valid && req_bus.ready, !req_bus.ready, "request taken while another is in flight")
   `GSDT_ASSERT_SAME(a_miss_no_key, clock, reset, rsp_bus.valid && !rsp_bus.found, rsp_bus.key_out == '0, "key_out set on a miss")
   `GSDT_ASSERT_AFTER_RESET(a_wipe_after_reset, clock, reset, !req_bus.ready, "request accepted during stamp wipe")

endmodule

bind generation_stamped_direct_table_core gsdt_checker u_gsdt_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
